>>> src/mde_pkg.sv
// ----------------------------------------------------------------------------
// mde_pkg
// shared constants, codes and the marker compare for the delimited extractor
// ----------------------------------------------------------------------------
package mde_pkg;

   localparam int MARK_BYTES = 8;
   localparam int MAX_VALUE  = 4096;

   localparam int BYTE_W     = 8;
   localparam int MARK_W     = BYTE_W * MARK_BYTES;
   localparam int LEN_W      = 4;
   localparam int FILL_W     = $clog2(MARK_BYTES + 1);
   localparam int CNT_W      = $clog2(MAX_VALUE + 1);
   localparam int STATUS_W   = 2;
   localparam int PHASE_W    = 2;
   localparam int RSP_DATA_W = ((BYTE_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - BYTE_W - CNT_W;
   localparam int CSR_ADDR_W = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_HEAD_PATTERN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HEAD_LENGTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TAIL_PATTERN = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TAIL_LENGTH  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_MORE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TAIL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ENDED     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_SEARCH  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_CAPTURE = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DONE    = 2'd2;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len_reg);
      logic [LEN_W-1:0] len;
      if (len_reg == '0) begin
         len = LEN_W'(1);
      end else if (len_reg > LEN_W'(MARK_BYTES)) begin
         len = LEN_W'(MARK_BYTES);
      end else begin
         len = len_reg;
      end
      return len;
   endfunction

   // newest byte sits in the top byte of the window
   function automatic logic marker_hit(input logic [MARK_W-1:0] win,
                                       input logic [FILL_W-1:0] fill,
                                       input logic [MARK_W-1:0] pat,
                                       input logic [LEN_W-1:0]  len_reg);
      logic [LEN_W-1:0]  len;
      logic [MARK_W-1:0] recent;
      logic [MARK_W-1:0] mask;
      len    = clamp_len(len_reg);
      recent = win >> {(LEN_W'(MARK_BYTES) - len), 3'b000};
      mask   = ~({MARK_W{1'b1}} << {len, 3'b000});
      return (FILL_W'(len) <= fill) && ((recent & mask) == (pat & mask));
   endfunction

endpackage

>>> src/marker_delimited_extractor.sv
// ----------------------------------------------------------------------------
// marker_delimited_extractor
// scans a byte stream for a head marker and returns the bytes that follow it
// ----------------------------------------------------------------------------
// One payload byte per item enters on req_; the block compares a sliding
// window of the newest bytes against a head marker of one to eight bytes.
// Once the head has matched, every later byte of that payload comes out on
// rsp_ with a running length, up to and including the last byte of the tail
// marker (status tail). A value also ends when the payload ends first
// (status ended) or when it reaches MAX_VALUE bytes (status truncated); the
// rest of that payload is then dropped. A head match on the final byte gives
// one item with status ended and length zero. An accepted item is held in
// the input register, then passes the window compare into the result
// register once that register is free or being taken. One item is accepted
// per cycle as long as the result register is free or being taken.
// The user must write configuration through csr_ only while no item is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module marker_delimited_extractor
   import mde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // payload_byte
   input  logic                  req_tlast,   // payload_end

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // value_byte, value_length, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser,   // status

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [MARK_W-1:0]     csr_wdata
);

   // configuration
   logic [MARK_W-1:0] head_pat_ff, head_pat_in;
   logic [LEN_W-1:0]  head_size_ff, head_size_in;
   logic [MARK_W-1:0] tail_pat_ff, tail_pat_in;
   logic [LEN_W-1:0]  tail_size_ff, tail_size_in;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic              s1_last_ff, s1_last_in;

   // scan state
   logic [MARK_W-1:0]  window_ff, window_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_len_ff, rsp_len_in;

   logic               out_free;
   logic               advance;
   logic [MARK_W-1:0]  window_new;
   logic [FILL_W-1:0]  fill_new;
   logic               head_hit;
   logic               tail_hit;
   logic [CNT_W-1:0]   count_inc;

   // result slot is free when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   // window with the current byte shifted in at the top
   assign window_new = {s1_byte_ff, window_ff[MARK_W-1:BYTE_W]};
   assign fill_new   = (fill_ff == FILL_W'(MARK_BYTES)) ? fill_ff : fill_ff + FILL_W'(1);
   assign head_hit   = marker_hit(window_new, fill_new, head_pat_ff, head_size_ff);
   assign tail_hit   = marker_hit(window_new, fill_new, tail_pat_ff, tail_size_ff);
   assign count_inc  = count_ff + CNT_W'(1);

   // configuration writes
   always_comb begin
      head_pat_in  = head_pat_ff;
      head_size_in = head_size_ff;
      tail_pat_in  = tail_pat_ff;
      tail_size_in = tail_size_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_HEAD_PATTERN: head_pat_in  = csr_wdata;
            REG_HEAD_LENGTH:  head_size_in = csr_wdata[LEN_W-1:0];
            REG_TAIL_PATTERN: tail_pat_in  = csr_wdata;
            REG_TAIL_LENGTH:  tail_size_in = csr_wdata[LEN_W-1:0];
            default:          head_pat_in  = head_pat_ff;
         endcase
      end
   end

   // input register load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_last_in  = req_tlast;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // scan step and result
   always_comb begin
      window_in     = window_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;

      if (advance) begin
         window_in = window_new;
         fill_in   = fill_new;
         unique case (phase_ff)
            PH_SEARCH: begin
               if (head_hit) begin
                  window_in = '0;
                  fill_in   = '0;
                  count_in  = '0;
                  phase_in  = PH_CAPTURE;
                  // head on the final byte: empty value
                  if (s1_last_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_byte_in   = '0;
                     rsp_status_in = ST_ENDED;
                     rsp_len_in    = '0;
                  end
               end
            end
            PH_CAPTURE: begin
               count_in     = count_inc;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = s1_byte_ff;
               rsp_len_in   = count_inc;
               // tail wins over the length limit
               if (tail_hit) begin
                  rsp_status_in = ST_TAIL;
                  phase_in      = PH_DONE;
               end else if (count_inc >= CNT_W'(MAX_VALUE)) begin
                  rsp_status_in = ST_TRUNCATED;
                  phase_in      = PH_DONE;
               end else if (s1_last_ff) begin
                  rsp_status_in = ST_ENDED;
               end else begin
                  rsp_status_in = ST_MORE;
               end
            end
            default: begin
               // value done: drop bytes until the payload ends
               phase_in = phase_ff;
            end
         endcase
         // payload end restarts the head search
         if (s1_last_ff) begin
            window_in = '0;
            fill_in   = '0;
            phase_in  = PH_SEARCH;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pat_ff  <= '0;
         head_size_ff <= LEN_W'(1);
         tail_pat_ff  <= '0;
         tail_size_ff <= LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         fill_ff      <= '0;
         phase_ff     <= PH_SEARCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_pat_ff  <= head_pat_in;
         head_size_ff <= head_size_in;
         tail_pat_ff  <= tail_pat_in;
         tail_size_ff <= tail_size_in;
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_last_ff    <= s1_last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;

   // count is held at zero while searching
   a_search_count_zero : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEARCH |-> count_ff == '0)
      else $error("count not zero during head search");

   // count never passes the value limit
   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VALUE))
      else $error("emitted count beyond limit");

   // payload end always restarts the search with a clean window
   a_end_restart : assert property (@(posedge clock) disable iff (reset)
      advance && s1_last_ff |=> phase_ff == PH_SEARCH && fill_ff == '0 && window_ff == '0)
      else $error("payload end did not restart the search");

   // an item marked more has a length inside the value limit
   a_more_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_MORE
         |-> rsp_len_ff != '0 && rsp_len_ff < CNT_W'(MAX_VALUE))
      else $error("bad length on a continuing item");

   // a tail match mid payload closes the value
   a_tail_closes : assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_CAPTURE && tail_hit && !s1_last_ff |=> phase_ff == PH_DONE)
      else $error("tail match did not close the value");

endmodule
